>>> design/lgcs_pkg.sv
// ----------------------------------------------------------------------------
// lgcs_pkg
// Shared constants and command/status types of the local goal cost selector.
// ----------------------------------------------------------------------------
package lgcs_pkg;

  localparam int MaxPoints = 1024;
  localparam int IdxW      = $clog2(MaxPoints);
  localparam int CntW      = $clog2(MaxPoints + 1);

  localparam logic [15:0] WeightReset = 16'd256;
  localparam logic [47:0] GoalInit    = 48'hFFFF_FFFF_FFFF;

  // register indexes
  localparam logic [0:0] RegDistW = 1'b0;
  localparam logic [0:0] RegCollW = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic            load;      // store the input beat
    logic            spr_start; // start spread pass
    logic            sqrt_go;   // launch square root on fetched point
    logic            sel_start; // start selection pass
    logic            sel_step;  // evaluate fetched point
    logic            rd_en;     // read stores at rd_addr
    logic [IdxW-1:0] rd_addr;
    logic            fetch_best;
    logic            finish;    // clear set state
  } lgcs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic            sqrt_done;
    logic            mul_done;
    logic [CntW-1:0] count;
    logic [IdxW-1:0] nearest;
    logic [IdxW-1:0] best;      // winner of the selection pass
  } lgcs_sts_t;

endpackage

>>> design/local_goal_cost_selector_unit.sv
// ----------------------------------------------------------------------------
// local_goal_cost_selector_unit
// Top level: stream ports, configuration port, controller and datapath.
// ----------------------------------------------------------------------------
// Each point beat is loaded as it is accepted. The beat with tlast starts the end
// passes: first a pass on the intermediate point, then per stored point a
// spread pass (read, launch, three squarings and a 34-step digit-by-digit
// square root) and a selection pass (read, launch and four partial products
// of the cross-multiplied cost); the winner is then read and fetched and the
// result beat follows, after which loading resumes. Input is held off during
// those passes and until the result beat is taken.
module local_goal_cost_selector_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // x[31:0] y[63:32] z[95:64] speed[127:96] goal_dist_sq[175:128] cost[207:176]
  input  logic [207:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // goal_x[31:0] goal_y[63:32] goal_z[95:64] goal_speed[127:96] goal_index[137:128]
  output logic [143:0] m_axis_tdata,
  // set_empty[0] overflowed[1]
  output logic [1:0]   m_axis_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  lgcs_pkg::lgcs_cmd_t cmd;
  lgcs_pkg::lgcs_sts_t sts;
  logic [31:0] ox, oy, oz, os;
  logic [9:0]  oi;
  logic        oe, oo;

  assign cfg_ready = 1'b1;

  lgcs_ctrl u_ctrl (
    .clk, .rst_n,
    .in_beat  (s_axis_tvalid & s_axis_tready),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .cmd, .sts
  );

  lgcs_datapath u_dp (
    .clk, .rst_n, .cmd, .sts,
    .px(s_axis_tdata[31:0]), .py(s_axis_tdata[63:32]), .pz(s_axis_tdata[95:64]),
    .pspeed(s_axis_tdata[127:96]), .pgoal(s_axis_tdata[175:128]),
    .pcost(s_axis_tdata[207:176]),
    .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_val(cfg_data),
    .o_x(ox), .o_y(oy), .o_z(oz), .o_speed(os), .o_index(oi),
    .o_empty(oe), .o_ovf(oo)
  );

  assign m_axis_tdata = {6'd0, oi, os, oz, oy, ox};
  assign m_axis_tuser = {oo, oe};
endmodule

>>> design/lgcs_datapath.sv
// ----------------------------------------------------------------------------
// lgcs_datapath
// Point stores, running min/max tracking, iterative square root and a
// multi-cycle cost evaluator for the selection pass.
// ----------------------------------------------------------------------------
module lgcs_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lgcs_pkg::lgcs_cmd_t       cmd,
  output lgcs_pkg::lgcs_sts_t       sts,
  input  logic [31:0]               px,
  input  logic [31:0]               py,
  input  logic [31:0]               pz,
  input  logic [31:0]               pspeed,
  input  logic [47:0]               pgoal,
  input  logic [31:0]               pcost,
  input  logic                      cfg_we,
  input  logic                      cfg_idx,
  input  logic [15:0]               cfg_val,
  output logic [31:0]               o_x,
  output logic [31:0]               o_y,
  output logic [31:0]               o_z,
  output logic [31:0]               o_speed,
  output logic [9:0]                o_index,
  output logic                      o_empty,
  output logic                      o_ovf
);
  localparam int IW = lgcs_pkg::IdxW;
  localparam int CW = lgcs_pkg::CntW;

  logic [31:0] x_mem [lgcs_pkg::MaxPoints];
  logic [31:0] y_mem [lgcs_pkg::MaxPoints];
  logic [31:0] z_mem [lgcs_pkg::MaxPoints];
  logic [31:0] s_mem [lgcs_pkg::MaxPoints];
  logic [31:0] c_mem [lgcs_pkg::MaxPoints];
  logic [33:0] d_mem [lgcs_pkg::MaxPoints];

  logic [31:0] rx_r, ry_r, rz_r, rs_r, rc_r;
  logic [33:0] rd_r;
  logic [IW-1:0] raddr_r;

  logic [CW-1:0] cnt_r;
  logic [IW-1:0] near_r;
  logic [47:0]   ngv_r;
  logic [31:0]   mc_r;
  logic [33:0]   ms_r;
  logic          drop_r;
  logic [15:0]   dw_r, cw_r;

  logic [31:0] cx_r, cy_r, cz_r;   // intermediate point
  logic        have_c_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dw_r <= lgcs_pkg::WeightReset;
      cw_r <= lgcs_pkg::WeightReset;
    end else if (cfg_we) begin
      if (cfg_idx == lgcs_pkg::RegDistW) dw_r <= cfg_val;
      else                               cw_r <= cfg_val;
    end
  end

  // load tracking
  logic store_ok;
  assign store_ok = cmd.load && (cnt_r < CW'(lgcs_pkg::MaxPoints));

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.finish) begin
      cnt_r  <= '0;
      near_r <= '0;
      ngv_r  <= lgcs_pkg::GoalInit;
      mc_r   <= '0;
      drop_r <= 1'b0;
    end else if (cmd.load) begin
      if (store_ok) begin
        if (cnt_r == '0 || pgoal < ngv_r) begin
          ngv_r  <= pgoal;
          near_r <= cnt_r[IW-1:0];
        end
        if (pcost > mc_r) mc_r <= pcost;
        cnt_r <= cnt_r + 1'b1;
      end else begin
        drop_r <= 1'b1;
      end
    end
  end

  // store writes and registered reads
  logic          sq_wr;
  logic [IW-1:0] sq_addr_r;
  logic [67:0]   res_step;
  always_ff @(posedge clk) begin
    if (store_ok) begin
      x_mem[cnt_r[IW-1:0]] <= px;
      y_mem[cnt_r[IW-1:0]] <= py;
      z_mem[cnt_r[IW-1:0]] <= pz;
      s_mem[cnt_r[IW-1:0]] <= pspeed;
      c_mem[cnt_r[IW-1:0]] <= pcost;
    end
    if (sq_wr) d_mem[sq_addr_r] <= res_step[33:0];
    if (cmd.rd_en) begin
      rx_r <= x_mem[cmd.rd_addr];
      ry_r <= y_mem[cmd.rd_addr];
      rz_r <= z_mem[cmd.rd_addr];
      rs_r <= s_mem[cmd.rd_addr];
      rc_r <= c_mem[cmd.rd_addr];
      rd_r <= d_mem[cmd.rd_addr];
      raddr_r <= cmd.rd_addr;
    end
  end

  // intermediate point latch: first read of the spread pass is the center
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.finish) have_c_r <= 1'b0;
    else if (cmd.spr_start) have_c_r <= 1'b0;
    else if (cmd.sqrt_go && !have_c_r) have_c_r <= 1'b1;
  end

  // square root: sum of the three squared differences, then 34 digit-by-digit steps
  logic [32:0] dx, dy, dz;
  function automatic logic [32:0] adiff(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] d;
    d = $signed({a[31], a}) - $signed({b[31], b});
    return d[32] ? 33'(-d) : 33'(d);
  endfunction
  logic [31:0] ax, ay, az;
  assign ax = have_c_r ? cx_r : rx_r;
  assign ay = have_c_r ? cy_r : ry_r;
  assign az = have_c_r ? cz_r : rz_r;
  assign dx = adiff(rx_r, ax);
  assign dy = adiff(ry_r, ay);
  assign dz = adiff(rz_r, az);

  logic [1:0]  sq_ph_r;
  logic        sq_busy_r;
  logic [67:0] sos_r;      // sum of squares, then running remainder
  logic [67:0] res_r;
  logic [67:0] one_r;      // current power of four
  logic [32:0] op_r [3];
  logic [65:0] prod;
  logic [67:0] trial;
  logic        fits;
  assign prod     = op_r[sq_ph_r] * op_r[sq_ph_r];
  assign trial    = res_r + one_r;
  assign fits     = (sos_r >= trial);
  assign res_step = fits ? ((res_r >> 1) + one_r) : (res_r >> 1);
  assign sq_wr    = sq_busy_r && sq_ph_r == 2'd3 && one_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_busy_r <= 1'b0;
      sq_ph_r   <= '0;
      ms_r      <= '0;
    end else begin
      if (cmd.finish) ms_r <= '0;
      if (cmd.sqrt_go) begin
        if (!have_c_r) begin
          cx_r <= rx_r; cy_r <= ry_r; cz_r <= rz_r;
        end
        op_r[0] <= dx; op_r[1] <= dy; op_r[2] <= dz;
        sos_r <= '0; res_r <= '0; one_r <= {2'b01, 66'd0};
        sq_ph_r <= 2'd0; sq_busy_r <= 1'b1; sq_addr_r <= raddr_r;
      end else if (sq_busy_r) begin
        if (sq_ph_r != 2'd3) begin
          sos_r   <= sos_r + 68'(prod);
          sq_ph_r <= sq_ph_r + 2'd1;
        end else begin
          if (fits) sos_r <= sos_r - trial;
          res_r <= res_step;
          one_r <= one_r >> 2;
          if (one_r[0]) begin
            sq_busy_r <= 1'b0;
            if (res_step[33:0] > ms_r) ms_r <= res_step[33:0];
          end
        end
      end
    end
  end
  assign sts.sqrt_done = sq_wr;

  // cost evaluation: four 25x34 partial multiplies, sequenced
  logic [33:0] msd, mcd;
  assign msd = ms_r != '0 ? ms_r : 34'd1;
  assign mcd = mc_r != '0 ? {2'b0, mc_r} : 34'd1;

  logic [2:0]  ev_ph_r;
  logic        ev_busy_r;
  logic [49:0] a1_r, a2_r;
  logic [99:0] t_r, best_r;
  logic [IW-1:0] best_i_r, cur_i_r;
  logic        first_r;
  logic [49:0] ma;
  logic [33:0] mb;
  logic [83:0] mp;
  assign ma = ev_ph_r[0] ? a2_r : a1_r;
  assign mb = ev_ph_r[0] ? msd  : mcd;
  // split each 50x34 product into two 25x34 halves
  assign mp = ev_ph_r[1] ? 84'(ma[49:25] * mb) << 25 : 84'(ma[24:0] * mb);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_busy_r <= 1'b0;
      ev_ph_r   <= '0;
      first_r   <= 1'b1;
    end else begin
      if (cmd.sel_start) first_r <= 1'b1;
      if (cmd.sel_step) begin
        a1_r <= 50'(dw_r * rd_r);
        a2_r <= (mc_r != '0) ? 50'(cw_r * rc_r) : '0;
        t_r <= '0; ev_ph_r <= '0; ev_busy_r <= 1'b1; cur_i_r <= raddr_r;
      end else if (ev_busy_r) begin
        t_r <= t_r + 100'(mp);
        if (ev_ph_r == 3'd3) begin
          ev_busy_r <= 1'b0;
          if (first_r || (t_r + 100'(mp)) < best_r) begin
            best_r   <= t_r + 100'(mp);
            best_i_r <= cur_i_r;
          end
          first_r <= 1'b0;
        end else begin
          ev_ph_r <= ev_ph_r + 3'd1;
        end
      end
    end
  end
  // phase order 0:a1 lo,1:a2 lo,2:a1 hi,3:a2 hi
  assign sts.mul_done = ev_busy_r && ev_ph_r == 3'd3;

  // result register
  always_ff @(posedge clk) begin
    if (cmd.fetch_best) begin
      o_empty <= (cnt_r == '0);
      o_ovf   <= drop_r;
      o_x     <= (cnt_r == '0) ? '0 : rx_r;
      o_y     <= (cnt_r == '0) ? '0 : ry_r;
      o_z     <= (cnt_r == '0) ? '0 : rz_r;
      o_speed <= (cnt_r == '0) ? '0 : rs_r;
      o_index <= (cnt_r == '0) ? '0 : 10'(raddr_r);
    end
  end

  assign sts.count   = cnt_r;
  assign sts.nearest = near_r;
  assign sts.best    = best_i_r;
endmodule

>>> design/lgcs_ctrl.sv
// ----------------------------------------------------------------------------
// lgcs_ctrl
// Sequencer: load, spread pass, selection pass, result handoff.
// ----------------------------------------------------------------------------
module lgcs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_beat,
  input  logic                in_last,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output lgcs_pkg::lgcs_cmd_t cmd,
  input  lgcs_pkg::lgcs_sts_t sts
);
  localparam int IW = lgcs_pkg::IdxW;
  localparam int CW = lgcs_pkg::CntW;

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_CRD   = 4'd1;  // read center
  localparam logic [3:0] S_SRD   = 4'd2;  // read spread point
  localparam logic [3:0] S_SGO   = 4'd3;
  localparam logic [3:0] S_SWT   = 4'd4;
  localparam logic [3:0] S_ERD   = 4'd5;
  localparam logic [3:0] S_EGO   = 4'd6;
  localparam logic [3:0] S_EWT   = 4'd7;
  localparam logic [3:0] S_BRD   = 4'd8;
  localparam logic [3:0] S_BFT   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;
  localparam logic [3:0] S_CGO   = 4'd11;
  localparam logic [3:0] S_CWT   = 4'd12;

  logic [3:0]    st_r, st_nxt;
  logic [CW-1:0] i_r, i_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD; i_r <= '0;
    end else begin
      st_r <= st_nxt; i_r <= i_nxt;
    end
  end

  assign in_ready  = (st_r == S_LOAD);
  assign out_valid = (st_r == S_OUT);

  always_comb begin
    st_nxt = st_r;
    i_nxt  = i_r;
    cmd    = '0;
    case (st_r)
      S_LOAD: begin
        cmd.load = in_beat;
        if (in_beat && in_last) st_nxt = S_CRD;
      end
      S_CRD: begin
        // center first so its coordinates are latched; empty set skips
        if (sts.count == '0) begin
          st_nxt = S_BRD;
        end else begin
          cmd.rd_en = 1'b1; cmd.rd_addr = sts.nearest;
          cmd.spr_start = 1'b1;
          st_nxt = S_CGO;
        end
      end
      S_CGO: begin
        cmd.sqrt_go = 1'b1; st_nxt = S_CWT;
      end
      S_CWT: begin
        if (sts.sqrt_done) begin i_nxt = '0; st_nxt = S_SRD; end
      end
      S_SRD: begin
        cmd.rd_en = 1'b1; cmd.rd_addr = i_r[IW-1:0]; st_nxt = S_SGO;
      end
      S_SGO: begin
        cmd.sqrt_go = 1'b1; st_nxt = S_SWT;
      end
      S_SWT: begin
        if (sts.sqrt_done) begin
          if (i_r + 1'b1 == sts.count) begin
            i_nxt = '0; st_nxt = S_ERD; cmd.sel_start = 1'b1;
          end else begin
            i_nxt = i_r + 1'b1; st_nxt = S_SRD;
          end
        end
      end
      S_ERD: begin
        cmd.rd_en = 1'b1; cmd.rd_addr = i_r[IW-1:0]; st_nxt = S_EGO;
      end
      S_EGO: begin
        cmd.sel_step = 1'b1; st_nxt = S_EWT;
      end
      S_EWT: begin
        if (sts.mul_done) begin
          if (i_r + 1'b1 == sts.count) st_nxt = S_BRD;
          else begin i_nxt = i_r + 1'b1; st_nxt = S_ERD; end
        end
      end
      S_BRD: begin
        cmd.fetch_best = 1'b0;
        cmd.rd_en = (sts.count != '0);
        cmd.sel_start = 1'b0;
        cmd.rd_addr = sts.best;
        st_nxt = S_BFT;
      end
      S_BFT: begin
        cmd.fetch_best = 1'b1; st_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin cmd.finish = 1'b1; st_nxt = S_LOAD; end
      end
      default: st_nxt = S_LOAD;
    endcase
  end
endmodule

>>> design/lgcs_checker.sv
// ----------------------------------------------------------------------------
// lgcs_checker
// Port-level checks of the local goal cost selector.
// ----------------------------------------------------------------------------
module lgcs_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         s_axis_tlast,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [143:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);
  // no input taken while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    m_axis_tvalid |-> !s_axis_tready) else $error("input ready during result");
  // last beat ends loading
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("still loading after last beat");
  // empty result carries zero payload
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("empty set with payload");
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");
endmodule

bind local_goal_cost_selector_unit lgcs_checker u_lgcs_checker (
  .clk, .rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tlast,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);

>>> test/local_goal_cost_selector_unit_tb.sv
// ----------------------------------------------------------------------------
// local_goal_cost_selector_unit_tb
// Drives sets of candidate waypoints through the selector, with random idle
// cycles on the input and output streams and weight changes between sets. A
// scoreboard models the intermediate point, the spreads and the weighted cost
// choice, and checks each goal beat field by field.
// ----------------------------------------------------------------------------
module local_goal_cost_selector_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth      = lgcs_pkg::MaxPoints;
  localparam int StallLimit = 200000;
  localparam int RandItems  = 1250;

  typedef struct {
    logic [31:0] x, y, z, speed;
    logic [9:0]  index;
    logic        empty, ovf;
  } goal_t;

  // --------------------------------------------------------------------------
  // Scoreboard: selector state, weights and queue of pending goals
  // --------------------------------------------------------------------------
  class goal_scoreboard;
    logic [31:0]  xs[Depth], ys[Depth], zs[Depth], speeds[Depth], costs[Depth];
    logic [127:0] spreads[Depth];
    int unsigned  count;
    int unsigned  near_idx;
    logic [47:0]  near_val;
    logic [31:0]  max_cost;
    logic [127:0] max_spread;
    bit           drop;
    logic [15:0]  dist_w, coll_w;
    goal_t        goals[$];
    int           errors;

    function new();
      dist_w = lgcs_pkg::WeightReset;
      coll_w = lgcs_pkg::WeightReset;
      errors = 0;
      clear_set();
    endfunction

    function void clear_set();
      count = 0; near_idx = 0; near_val = lgcs_pkg::GoalInit;
      max_cost = 0; max_spread = 0; drop = 0;
    endfunction

    function void set_weight(logic [0:0] idx, logic [15:0] val);
      if (idx == lgcs_pkg::RegDistW) dist_w = val;
      else coll_w = val;
    endfunction

    function logic [127:0] abs_diff(logic [31:0] a, logic [31:0] b);
      longint d;
      d = longint'($signed(a)) - longint'($signed(b));
      return (d < 0) ? 128'(-d) : 128'(d);
    endfunction

    function logic [127:0] isqrt(logic [127:0] v);
      logic [127:0] r, c;
      r = 0;
      for (int b = 34; b >= 0; b--) begin
        c = r | (128'd1 << b);
        if (c * c <= v) r = c;
      end
      return r;
    endfunction

    // note one accepted point; a last point yields one expected goal
    function void note_point(logic [31:0] x, y, z, spd, logic [47:0] gd,
                             logic [31:0] cost, logic last);
      goal_t        g;
      logic [127:0] dx, dy, dz, ms, mc, t, best_t;
      int unsigned  c, best;
      if (count < Depth) begin
        xs[count] = x; ys[count] = y; zs[count] = z;
        speeds[count] = spd; costs[count] = cost;
        if (count == 0 || gd < near_val) begin
          near_val = gd;
          near_idx = count;
        end
        if (cost > max_cost) max_cost = cost;
        count++;
      end else begin
        drop = 1;
      end
      if (!last) return;
      g = '{default: '0};
      g.ovf = drop;
      if (count == 0) begin
        g.empty = 1;
      end else begin
        c = near_idx;
        for (int i = 0; i < count; i++) begin
          dx = abs_diff(xs[i], xs[c]);
          dy = abs_diff(ys[i], ys[c]);
          dz = abs_diff(zs[i], zs[c]);
          spreads[i] = isqrt(dx * dx + dy * dy + dz * dz);
          if (spreads[i] > max_spread) max_spread = spreads[i];
        end
        ms = (max_spread != 0) ? max_spread : 128'd1;
        mc = (max_cost != 0) ? 128'(max_cost) : 128'd1;
        best = 0;
        best_t = 0;
        // cross-multiplied cost over the common denominator
        for (int i = 0; i < count; i++) begin
          t = 128'(dist_w) * spreads[i] * mc;
          if (max_cost != 0) t = t + 128'(coll_w) * 128'(costs[i]) * ms;
          if (i == 0 || t < best_t) begin
            best_t = t;
            best = i;
          end
        end
        g.x = xs[best]; g.y = ys[best]; g.z = zs[best];
        g.speed = speeds[best];
        g.index = best[9:0];
      end
      goals = {goals, g};
      clear_set();
    endfunction

    function void check_goal(logic [143:0] data, logic [1:0] user);
      goal_t e;
      if (goals.size() == 0) begin
        $display("%0t: unexpected goal beat, got %h/%h", $time, data, user);
        errors++;
        return;
      end
      e = goals.pop_front();
      if (data[31:0] !== e.x) begin
        $display("%0t: goal_x exp %h got %h", $time, e.x, data[31:0]); errors++;
      end
      if (data[63:32] !== e.y) begin
        $display("%0t: goal_y exp %h got %h", $time, e.y, data[63:32]); errors++;
      end
      if (data[95:64] !== e.z) begin
        $display("%0t: goal_z exp %h got %h", $time, e.z, data[95:64]); errors++;
      end
      if (data[127:96] !== e.speed) begin
        $display("%0t: goal_speed exp %h got %h", $time, e.speed, data[127:96]);
        errors++;
      end
      if (data[137:128] !== e.index) begin
        $display("%0t: goal_index exp %0d got %0d", $time, e.index, data[137:128]);
        errors++;
      end
      if (user[0] !== e.empty) begin
        $display("%0t: set_empty exp %b got %b", $time, e.empty, user[0]); errors++;
      end
      if (user[1] !== e.ovf) begin
        $display("%0t: overflowed exp %b got %b", $time, e.ovf, user[1]); errors++;
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst_n = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [207:0] s_axis_tdata = '0;
  logic         s_axis_tlast = 0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [143:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [0:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;

  goal_scoreboard board = new();
  bit             quiet = 0;   // no idle cycles on either side
  int             stall_cycles = 0;

  local_goal_cost_selector_unit dut (.*);

  always #6 clk = ~clk;

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 3);
  endfunction

  // one point beat; valid stays high into the next beat when no gap is drawn
  task automatic send_point(logic [31:0] x, y, z, spd, logic [47:0] gd,
                            logic [31:0] cost, logic last);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {cost, gd, spd, z, y, x};
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    board.note_point(x, y, z, spd, gd, cost, last);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    board.set_weight(idx, val);
  endtask

  // hold input until every goal is back, then change the weights
  task automatic set_weights(logic [15:0] dw, logic [15:0] cw);
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (board.goals.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    write_reg(lgcs_pkg::RegDistW, dw);
    write_reg(lgcs_pkg::RegCollW, cw);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return 32'($signed($urandom_range(0, 8)) - 4) << 16;
      1: case ($urandom_range(0, 3))
           0: return 32'h8000_0000;
           1: return 32'h7FFF_FFFF;
           2: return 32'h0;
           default: return 32'hFFFF_FFFF;
         endcase
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_set(int size);
    int          mode;
    bit          zero_cost;
    logic [47:0] gd;
    logic [31:0] cost;
    mode = $urandom_range(0, 5) < 3 ? 0 : ($urandom_range(0, 3) == 0 ? 1 : 2);
    zero_cost = ($urandom_range(0, 5) == 0);
    quiet = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < size; i++) begin
      case ($urandom_range(0, 3))
        0: gd = 48'($urandom_range(0, 3));
        1: gd = lgcs_pkg::GoalInit;
        default: gd = 48'({$urandom, $urandom});
      endcase
      case ($urandom_range(0, 3))
        0: cost = $urandom_range(0, 4) << 16;
        1: cost = 32'hFFFF_FFFF;
        default: cost = $urandom;
      endcase
      if (zero_cost) cost = 0;
      send_point(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                 $urandom, gd, cost, i == size - 1);
    end
  endtask

  // result side: random stalls, check each accepted beat
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        m_axis_tready <= 0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1;
      do @(posedge clk); while (!m_axis_tvalid);
      board.check_goal(m_axis_tdata, m_axis_tuser);
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int sent, size;
    bit big_done;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: single point, tied points, extreme positions and speeds
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0, 48'h0, 32'h0, 1);
    send_point(32'h0, 32'h0, 32'h0, 32'h1, 48'h5, 32'h0, 0);
    send_point(32'h0, 32'h0, 32'h0, 32'h2, 48'h5, 32'h0, 0);
    send_point(32'h0, 32'h0, 32'h0, 32'h3, 48'h5, 32'h0, 1);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
               lgcs_pkg::GoalInit, 32'hFFFF_FFFF, 0);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0,
               48'h0, 32'h0, 0);
    send_point(32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h1234_5678,
               48'h1, 32'h0001_0000, 1);
    set_weights(16'h0000, 16'hFFFF);
    send_point(32'h0001_0000, 32'h0, 32'h0, 32'h1, 48'h2, 32'h0003_0000, 0);
    send_point(32'h0005_0000, 32'h0, 32'h0, 32'h2, 48'h1, 32'h0001_0000, 0);
    send_point(32'h0009_0000, 32'h0, 32'h0, 32'h3, 48'h1, 32'h0001_0000, 1);
    set_weights(16'hFFFF, 16'h0000);
    send_point(32'h0001_0000, 32'h0, 32'h0, 32'h1, 48'h2, 32'h0003_0000, 0);
    send_point(32'h0005_0000, 32'h0, 32'h0, 32'h2, 48'h1, 32'h0001_0000, 0);
    send_point(32'h0009_0000, 32'h0, 32'h0, 32'h3, 48'h1, 32'h0001_0000, 1);
    set_weights(16'h0000, 16'h0000);
    send_point(32'h0001_0000, 32'h0, 32'h0, 32'h1, 48'h2, 32'h0003_0000, 0);
    send_point(32'h0005_0000, 32'h0, 32'h0, 32'h2, 48'h1, 32'h0001_0000, 1);
    set_weights(lgcs_pkg::WeightReset, lgcs_pkg::WeightReset);

    // random sets; one set runs past the store depth
    sent = 0;
    big_done = 0;
    while (sent < RandItems) begin
      if (!big_done && sent > RandItems / 2) begin
        size = Depth + 6;
        big_done = 1;
      end else if ($urandom_range(0, 19) == 0) begin
        size = $urandom_range(9, 40);
      end else begin
        size = $urandom_range(1, 6);
      end
      send_random_set(size);
      sent += size;
      if ($urandom_range(0, 24) == 0)
        set_weights($urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom),
                    $urandom_range(0, 3) == 0 ? 16'h0 : 16'($urandom));
    end
    s_axis_tvalid <= 0;

    while (board.goals.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (board.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/lgcs_pkg.sv
design/lgcs_datapath.sv
design/lgcs_ctrl.sv
design/local_goal_cost_selector_unit.sv
design/lgcs_checker.sv
test/local_goal_cost_selector_unit_tb.sv
